// File: rtl/cstf_pkg.sv
// Shared types, constants and facelet tables for the cube state to facelet converter.
package cstf_pkg;

  localparam int COLOR_W     = 3;
  localparam int NUM_SLOTS   = 54;
  localparam int NUM_FACES   = 6;
  localparam int FACE_SLOTS  = 9;
  localparam int NUM_CORNERS = 8;
  localparam int NUM_EDGES   = 12;
  localparam int NUM_CYCLES  = 13;
  localparam int NUM_CENTERS = 6;

  typedef logic [63:0]                     word_t;
  typedef logic [COLOR_W-1:0]              color_t;
  typedef logic [5:0]                      slot_t;
  typedef logic [2:0]                      face_t;
  typedef logic [FACE_SLOTS*COLOR_W-1:0]   face_colors_t;
  typedef logic [NUM_SLOTS*COLOR_W-1:0]    slots_t;

  localparam face_t LAST_FACE = 3'd5;

  localparam logic [3:0] CORNER_MAX = 4'd8;
  localparam logic [3:0] EDGE_MAX   = 4'd12;
  localparam logic [3:0] TWIST_ONE  = 4'd1;
  localparam logic [3:0] TWIST_TWO  = 4'd2;
  localparam logic [3:0] TWIST_MAX  = 4'd3;

  localparam color_t CORNER_COLS [NUM_CORNERS][3] = '{
    '{3'd1, 3'd2, 3'd3}, '{3'd1, 3'd3, 3'd4}, '{3'd1, 3'd4, 3'd5}, '{3'd1, 3'd5, 3'd2},
    '{3'd6, 3'd3, 3'd2}, '{3'd6, 3'd4, 3'd3}, '{3'd6, 3'd5, 3'd4}, '{3'd6, 3'd2, 3'd5}
  };

  localparam slot_t CORNER_SLOT [NUM_CORNERS][3] = '{
    '{6'd34, 6'd43, 6'd54}, '{6'd36, 6'd52, 6'd18}, '{6'd30, 6'd16, 6'd27},
    '{6'd28, 6'd25, 6'd45}, '{6'd1,  6'd48, 6'd37}, '{6'd3,  6'd12, 6'd46},
    '{6'd9,  6'd21, 6'd10}, '{6'd7,  6'd39, 6'd19}
  };

  localparam logic CORNER_YFIRST [NUM_CORNERS] = '{
    1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0
  };

  localparam color_t EDGE_COLS [NUM_EDGES][2] = '{
    '{3'd1, 3'd2}, '{3'd1, 3'd3}, '{3'd1, 3'd4}, '{3'd1, 3'd5},
    '{3'd2, 3'd3}, '{3'd4, 3'd3}, '{3'd4, 3'd5}, '{3'd2, 3'd5},
    '{3'd6, 3'd2}, '{3'd6, 3'd3}, '{3'd6, 3'd4}, '{3'd6, 3'd5}
  };

  localparam slot_t EDGE_SLOT [NUM_EDGES][2] = '{
    '{6'd31, 6'd44}, '{6'd35, 6'd53}, '{6'd33, 6'd17}, '{6'd29, 6'd26},
    '{6'd40, 6'd51}, '{6'd15, 6'd49}, '{6'd13, 6'd24}, '{6'd42, 6'd22},
    '{6'd4,  6'd38}, '{6'd2,  6'd47}, '{6'd6,  6'd11}, '{6'd8,  6'd20}
  };

  localparam slot_t CENTER_SLOT [NUM_CENTERS] = '{
    6'd32, 6'd41, 6'd50, 6'd14, 6'd23, 6'd5
  };

  localparam color_t CENTER_COLOR [NUM_CENTERS] = '{
    3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6
  };

  localparam slot_t ROT_CYCLE [NUM_CYCLES][4] = '{
    '{6'd1,  6'd7,  6'd9,  6'd3},  '{6'd4,  6'd8,  6'd6,  6'd2},
    '{6'd37, 6'd19, 6'd10, 6'd46}, '{6'd38, 6'd20, 6'd11, 6'd47},
    '{6'd39, 6'd21, 6'd12, 6'd48}, '{6'd40, 6'd22, 6'd13, 6'd49},
    '{6'd41, 6'd23, 6'd14, 6'd50}, '{6'd42, 6'd24, 6'd15, 6'd51},
    '{6'd43, 6'd25, 6'd16, 6'd52}, '{6'd44, 6'd26, 6'd17, 6'd53},
    '{6'd45, 6'd27, 6'd18, 6'd54}, '{6'd34, 6'd28, 6'd30, 6'd36},
    '{6'd31, 6'd29, 6'd33, 6'd35}
  };

endpackage

// File: rtl/cstf_decode.sv
// Packet decode: corner and edge codes to 54 rotated facelet colors plus invalid flag.
module cstf_decode (
  input  cstf_pkg::word_t  corner_word,
  input  cstf_pkg::word_t  edge_word,
  output cstf_pkg::slots_t colors,
  output logic             bad
);
  import cstf_pkg::*;

  color_t f [NUM_SLOTS];
  color_t g [NUM_SLOTS];

  always_comb begin
    logic [3:0] pos;
    logic [3:0] tw;
    logic [2:0] cp;
    logic [3:0] ep;
    logic       flip;
    bad  = 1'b0;
    pos  = '0;
    tw   = '0;
    cp   = '0;
    ep   = '0;
    flip = 1'b0;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      f[s] = '0;
    end
    for (int c = 0; c < NUM_CENTERS; c++) begin
      f[CENTER_SLOT[c] - 6'd1] = CENTER_COLOR[c];
    end
    for (int i = 0; i < NUM_CORNERS; i++) begin
      pos = corner_word[60-4*i +: 4];
      tw  = corner_word[28-4*i +: 4];
      if (pos < 4'd1 || pos > CORNER_MAX || tw < TWIST_ONE || tw > TWIST_MAX) begin
        bad = 1'b1;
      end else begin
        cp = 3'(pos - 4'd1);
        if (CORNER_YFIRST[i] && tw != TWIST_MAX) begin
          tw = tw ^ 4'd3;
        end
        case (tw)
          TWIST_ONE: begin
            f[CORNER_SLOT[i][0] - 6'd1] = CORNER_COLS[cp][2];
            f[CORNER_SLOT[i][1] - 6'd1] = CORNER_COLS[cp][0];
            f[CORNER_SLOT[i][2] - 6'd1] = CORNER_COLS[cp][1];
          end
          TWIST_TWO: begin
            f[CORNER_SLOT[i][0] - 6'd1] = CORNER_COLS[cp][1];
            f[CORNER_SLOT[i][1] - 6'd1] = CORNER_COLS[cp][2];
            f[CORNER_SLOT[i][2] - 6'd1] = CORNER_COLS[cp][0];
          end
          default: begin
            f[CORNER_SLOT[i][0] - 6'd1] = CORNER_COLS[cp][0];
            f[CORNER_SLOT[i][1] - 6'd1] = CORNER_COLS[cp][1];
            f[CORNER_SLOT[i][2] - 6'd1] = CORNER_COLS[cp][2];
          end
        endcase
      end
    end
    for (int i = 0; i < NUM_EDGES; i++) begin
      pos  = edge_word[60-4*i +: 4];
      flip = edge_word[15-i];
      if (pos < 4'd1 || pos > EDGE_MAX) begin
        bad = 1'b1;
      end else begin
        ep = pos - 4'd1;
        f[EDGE_SLOT[i][0] - 6'd1] = flip ? EDGE_COLS[ep][1] : EDGE_COLS[ep][0];
        f[EDGE_SLOT[i][1] - 6'd1] = flip ? EDGE_COLS[ep][0] : EDGE_COLS[ep][1];
      end
    end
  end

  always_comb begin
    g = f;
    for (int c = 0; c < NUM_CYCLES; c++) begin
      g[ROT_CYCLE[c][1] - 6'd1] = f[ROT_CYCLE[c][0] - 6'd1];
      g[ROT_CYCLE[c][2] - 6'd1] = f[ROT_CYCLE[c][1] - 6'd1];
      g[ROT_CYCLE[c][3] - 6'd1] = f[ROT_CYCLE[c][2] - 6'd1];
      g[ROT_CYCLE[c][0] - 6'd1] = f[ROT_CYCLE[c][3] - 6'd1];
    end
  end

  always_comb begin
    for (int s = 0; s < NUM_SLOTS; s++) begin
      colors[COLOR_W*s +: COLOR_W] = bad ? '0 : g[s];
    end
  end

endmodule

// File: rtl/cube_state_to_facelets_core.sv
// Top level of the cube state to facelet converter: packet register, face buffer, face output.
//
// Input channel: pkt_valid / pkt_stall carry one 16-byte packet as corner_word and edge_word.
// Output channel: face_valid / face_stall carry six face transfers per packet, face_index 0..5
// in order, with the nine colors of that face, the packet's invalid flag, and last on face 5.
// A transfer happens at a rising edge where valid is high and stall is low.
// A packet moves through the packet register and face buffer into the output register.
// Throughput: one face per cycle unless the receiver stalls; the decoded packet is held
// in a face buffer and read out one face per cycle, which sets that rate.
// The packet register takes the next packet while the buffer still drains, and the buffer
// refills in the same cycle its last face leaves.
// Reset (rst, synchronous) empties the packet register, the buffer and the output register.
// While the receiver stalls, the output register holds its face and a full buffer waits; once the
// packet register is also full, pkt_stall rises.
module cube_state_to_facelets_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pkt_valid,
  output logic                   pkt_stall,
  input  cstf_pkg::word_t        corner_word,
  input  cstf_pkg::word_t        edge_word,
  output logic                   face_valid,
  input  logic                   face_stall,
  output cstf_pkg::face_t        face_index,
  output cstf_pkg::face_colors_t face_colors,
  output logic                   invalid,
  output logic                   last
);
  import cstf_pkg::*;

  logic   in_full;
  word_t  cw;
  word_t  ew;
  slots_t dec_colors;
  logic   dec_bad;
  logic   buf_full;
  slots_t buf_colors;
  logic   buf_bad;
  face_t  face_cnt;
  logic   out_load;
  logic   buf_drain;
  logic   buf_load;

  cstf_decode u_decode (
    .corner_word (cw),
    .edge_word   (ew),
    .colors      (dec_colors),
    .bad         (dec_bad)
  );

  assign out_load  = !face_valid || !face_stall;
  assign buf_drain = buf_full && out_load && face_cnt == LAST_FACE;
  assign buf_load  = in_full && (!buf_full || buf_drain);
  assign pkt_stall = in_full && !buf_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!pkt_stall) begin
      in_full <= pkt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_valid && !pkt_stall) begin
      cw <= corner_word;
      ew <= edge_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_full <= 1'b0;
      face_cnt <= '0;
    end else if (buf_load) begin
      buf_full <= 1'b1;
      face_cnt <= '0;
    end else if (buf_drain) begin
      buf_full <= 1'b0;
    end else if (buf_full && out_load) begin
      face_cnt <= face_cnt + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (buf_load) begin
      buf_colors <= dec_colors;
      buf_bad    <= dec_bad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      face_valid <= 1'b0;
    end else if (out_load) begin
      face_valid <= buf_full;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && buf_full) begin
      face_index  <= face_cnt;
      face_colors <= buf_colors[FACE_SLOTS*COLOR_W*face_cnt +: FACE_SLOTS*COLOR_W];
      invalid     <= buf_bad;
      last        <= face_cnt == LAST_FACE;
    end
  end

`ifndef SYNTHESIS
  a_last_on_final_face: assert property (@(posedge clk) disable iff (rst)
    face_valid && last |-> face_index == LAST_FACE)
    else $error("last set on a face other than the final one");

  a_faces_in_sequence: assert property (@(posedge clk) disable iff (rst)
    face_valid && !face_stall && !last |=>
      face_valid && face_index == $past(face_index) + 3'd1)
    else $error("face sequence broken within a packet");

  a_invalid_zeroes: assert property (@(posedge clk) disable iff (rst)
    face_valid && invalid |-> face_colors == '0)
    else $error("invalid packet shows nonzero colors");

  a_buffer_refill: assert property (@(posedge clk) disable iff (rst)
    in_full && !buf_full |-> !pkt_stall)
    else $error("packet stalled while the face buffer is empty");
`endif

endmodule

// File: sim/cube_state_to_facelets_core_tb.sv
// Self-checking testbench for the cube state to facelet converter: directed table plus random packets.
module cube_state_to_facelets_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cstf_pkg::*;

  localparam int SEND_COUNT = 330;
  localparam int PHASE_LEN  = 110;
  localparam int HOLD_LEN   = 60;
  localparam int SETTLE     = 10;

  localparam int CRN_COLOR [8][3] = '{
    '{1, 2, 3}, '{1, 3, 4}, '{1, 4, 5}, '{1, 5, 2},
    '{6, 3, 2}, '{6, 4, 3}, '{6, 5, 4}, '{6, 2, 5}
  };
  localparam int CRN_AT [8][3] = '{
    '{34, 43, 54}, '{36, 52, 18}, '{30, 16, 27}, '{28, 25, 45},
    '{1, 48, 37}, '{3, 12, 46}, '{9, 21, 10}, '{7, 39, 19}
  };
  localparam bit CRN_SWAP [8] = '{0, 1, 0, 1, 1, 0, 1, 0};
  localparam int EDG_COLOR [12][2] = '{
    '{1, 2}, '{1, 3}, '{1, 4}, '{1, 5}, '{2, 3}, '{4, 3},
    '{4, 5}, '{2, 5}, '{6, 2}, '{6, 3}, '{6, 4}, '{6, 5}
  };
  localparam int EDG_AT [12][2] = '{
    '{31, 44}, '{35, 53}, '{33, 17}, '{29, 26}, '{40, 51}, '{15, 49},
    '{13, 24}, '{42, 22}, '{4, 38}, '{2, 47}, '{6, 11}, '{8, 20}
  };
  localparam int CTR_AT [6] = '{32, 41, 50, 14, 23, 5};
  localparam int TURNS [13][4] = '{
    '{1, 7, 9, 3}, '{4, 8, 6, 2}, '{37, 19, 10, 46}, '{38, 20, 11, 47},
    '{39, 21, 12, 48}, '{40, 22, 13, 49}, '{41, 23, 14, 50}, '{42, 24, 15, 51},
    '{43, 25, 16, 52}, '{44, 26, 17, 53}, '{45, 27, 18, 54}, '{34, 28, 30, 36},
    '{31, 29, 33, 35}
  };

  typedef struct packed {
    word_t cw;
    word_t ew;
    logic  bad;
  } pkt_row_t;

  localparam int DIR_ROWS = 20;
  localparam pkt_row_t DIRECTED [DIR_ROWS] = '{
    '{64'h12345678_33333333, 64'h123456789ABC_0000, 1'b0},
    '{64'h12345678_33333333, 64'h123456789ABC_FFFF, 1'b0},
    '{64'h12345678_11111111, 64'h123456789ABC_0000, 1'b0},
    '{64'h12345678_22222222, 64'h123456789ABC_AAA5, 1'b0},
    '{64'h87654321_12312312, 64'hCBA987654321_5550, 1'b0},
    '{64'h11111111_33333333, 64'h111111111111_0000, 1'b0},
    '{64'h88888888_22222222, 64'hCCCCCCCCCCCC_FFF0, 1'b0},
    '{64'h00000000_00000000, 64'h000000000000_0000, 1'b1},
    '{64'hFFFFFFFF_FFFFFFFF, 64'hFFFFFFFFFFFF_FFFF, 1'b1},
    '{64'h02345678_33333333, 64'h123456789ABC_0000, 1'b1},
    '{64'h12345679_33333333, 64'h123456789ABC_0000, 1'b1},
    '{64'hF2345678_33333333, 64'h123456789ABC_0000, 1'b1},
    '{64'h12345678_33333330, 64'h123456789ABC_0000, 1'b1},
    '{64'h12345678_43333333, 64'h123456789ABC_0000, 1'b1},
    '{64'h12345678_333F3333, 64'h123456789ABC_0000, 1'b1},
    '{64'h12345678_33333333, 64'h023456789ABC_0000, 1'b1},
    '{64'h12345678_33333333, 64'h123456789ABD_0000, 1'b1},
    '{64'h12345678_33333333, 64'hF23456789ABC_0000, 1'b1},
    '{64'h12345678_33333333, 64'h123456789ABC_000F, 1'b0},
    '{64'h56781234_21321321, 64'h9ABC12345678_0F00, 1'b0}
  };

  typedef struct packed {
    face_t        idx;
    face_colors_t cols;
    logic         bad;
    logic         last;
  } face_exp_t;

  logic         clk;
  logic         rst;
  logic         pkt_valid;
  logic         pkt_stall;
  word_t        corner_word;
  word_t        edge_word;
  logic         face_valid;
  logic         face_stall;
  face_t        face_index;
  face_colors_t face_colors;
  logic         invalid;
  logic         last;

  face_exp_t face_q [$];
  int        phase;
  int        errors;
  int        packets_sent;
  int        bad_packets;
  int        faces_checked;

  cube_state_to_facelets_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .pkt_valid   (pkt_valid),
    .pkt_stall   (pkt_stall),
    .corner_word (corner_word),
    .edge_word   (edge_word),
    .face_valid  (face_valid),
    .face_stall  (face_stall),
    .face_index  (face_index),
    .face_colors (face_colors),
    .invalid     (invalid),
    .last        (last)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic slots_t facelet_colors(input word_t cw, input word_t ew, output logic bad);
    color_t     f [55];
    color_t     hold;
    logic [3:0] pos;
    logic [3:0] tw;
    logic       flip;
    slots_t     packed_slots;
    bad = 1'b0;
    foreach (f[s]) f[s] = '0;
    for (int c = 0; c < NUM_CENTERS; c++) f[CTR_AT[c]] = color_t'(c + 1);
    for (int i = 0; i < NUM_CORNERS; i++) begin
      pos = cw[63 - 4 * i -: 4];
      tw  = cw[31 - 4 * i -: 4];
      if (pos < 1 || pos > CORNER_MAX || tw < TWIST_ONE || tw > TWIST_MAX) begin
        bad = 1'b1;
      end else begin
        if (CRN_SWAP[i] && tw != TWIST_MAX) tw ^= TWIST_MAX;
        case (tw)
          TWIST_ONE: begin
            f[CRN_AT[i][0]] = color_t'(CRN_COLOR[pos - 1][2]);
            f[CRN_AT[i][1]] = color_t'(CRN_COLOR[pos - 1][0]);
            f[CRN_AT[i][2]] = color_t'(CRN_COLOR[pos - 1][1]);
          end
          TWIST_TWO: begin
            f[CRN_AT[i][0]] = color_t'(CRN_COLOR[pos - 1][1]);
            f[CRN_AT[i][1]] = color_t'(CRN_COLOR[pos - 1][2]);
            f[CRN_AT[i][2]] = color_t'(CRN_COLOR[pos - 1][0]);
          end
          default: begin
            f[CRN_AT[i][0]] = color_t'(CRN_COLOR[pos - 1][0]);
            f[CRN_AT[i][1]] = color_t'(CRN_COLOR[pos - 1][1]);
            f[CRN_AT[i][2]] = color_t'(CRN_COLOR[pos - 1][2]);
          end
        endcase
      end
    end
    for (int i = 0; i < NUM_EDGES; i++) begin
      pos  = ew[63 - 4 * i -: 4];
      flip = ew[15 - i];
      if (pos < 1 || pos > EDGE_MAX) begin
        bad = 1'b1;
      end else begin
        f[EDG_AT[i][0]] = color_t'(EDG_COLOR[pos - 1][flip ? 1 : 0]);
        f[EDG_AT[i][1]] = color_t'(EDG_COLOR[pos - 1][flip ? 0 : 1]);
      end
    end
    for (int r = 0; r < NUM_CYCLES; r++) begin
      hold           = f[TURNS[r][3]];
      f[TURNS[r][3]] = f[TURNS[r][2]];
      f[TURNS[r][2]] = f[TURNS[r][1]];
      f[TURNS[r][1]] = f[TURNS[r][0]];
      f[TURNS[r][0]] = hold;
    end
    packed_slots = '0;
    if (!bad) begin
      for (int s = 1; s <= NUM_SLOTS; s++) packed_slots[COLOR_W * (s - 1) +: COLOR_W] = f[s];
    end
    return packed_slots;
  endfunction

  function automatic void random_packet(output word_t cw, output word_t ew);
    int roll;
    int v;
    int at;
    roll = $urandom_range(99);
    for (int i = 0; i < NUM_CORNERS; i++) begin
      cw[63 - 4 * i -: 4] = 4'($urandom_range(1, 8));
      cw[31 - 4 * i -: 4] = 4'($urandom_range(1, 3));
    end
    for (int i = 0; i < NUM_EDGES; i++) ew[63 - 4 * i -: 4] = 4'($urandom_range(1, 12));
    ew[15:0] = 16'($urandom);
    if (roll >= 95) begin
      cw = {$urandom, $urandom};
      ew = {$urandom, $urandom};
    end else if (roll >= 85) begin
      case ($urandom_range(2))
        0: begin
          v  = $urandom_range(0, 7);
          at = $urandom_range(0, 7);
          cw[63 - 4 * at -: 4] = 4'(v == 0 ? 0 : v + 8);
        end
        1: begin
          v  = $urandom_range(0, 12);
          at = $urandom_range(0, 7);
          cw[31 - 4 * at -: 4] = 4'(v == 0 ? 0 : v + 3);
        end
        default: begin
          v  = $urandom_range(0, 3);
          at = $urandom_range(0, 11);
          ew[63 - 4 * at -: 4] = 4'(v == 0 ? 0 : v + 12);
        end
      endcase
    end
  endfunction

  task automatic queue_faces(input word_t cw, input word_t ew, input logic typed_bad);
    slots_t    slots;
    logic      bad;
    face_exp_t e;
    if (typed_bad) begin
      slots = '0;
      bad   = 1'b1;
    end else begin
      slots = facelet_colors(cw, ew, bad);
    end
    packets_sent++;
    if (bad) bad_packets++;
    for (int i = 0; i < NUM_FACES; i++) begin
      e.idx  = face_t'(i);
      e.cols = slots[FACE_SLOTS * COLOR_W * i +: FACE_SLOTS * COLOR_W];
      e.bad  = bad;
      e.last = (face_t'(i) == LAST_FACE);
      face_q.push_back(e);
    end
  endtask

  task automatic send_packet(input word_t cw, input word_t ew, input logic typed_bad);
    int gap_pct;
    gap_pct = (phase == 0) ? 26 : (phase == 1) ? 45 : 0;
    while ($urandom_range(99) < gap_pct) begin
      pkt_valid <= 1'b0;
      @(negedge clk);
    end
    pkt_valid   <= 1'b1;
    corner_word <= cw;
    edge_word   <= ew;
    do @(posedge clk); while (pkt_stall);
    queue_faces(cw, ew, typed_bad);
    @(negedge clk);
  endtask

  initial begin
    word_t cw;
    word_t ew;
    rst         = 1'b1;
    pkt_valid   = 1'b0;
    corner_word = '0;
    edge_word   = '0;
    phase       = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int r = 0; r < DIR_ROWS; r++) send_packet(DIRECTED[r].cw, DIRECTED[r].ew, DIRECTED[r].bad);
    for (int n = 0; n < SEND_COUNT; n++) begin
      phase = n / PHASE_LEN;
      random_packet(cw, ew);
      send_packet(cw, ew, 1'b0);
    end
    pkt_valid <= 1'b0;
    while (face_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    $display("Sent %0d packets, %0d of them with out-of-range codes; checked %0d face transfers.",
             packets_sent, bad_packets, faces_checked);
    $display("Covered sender and receiver gaps, a long output hold-off and back-to-back packets.");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    int hold_left;
    bit held;
    int stall_pct;
    face_stall = 1'b0;
    hold_left  = 0;
    held       = 1'b0;
    forever begin
      @(negedge clk);
      if (phase == 2 && !held) begin
        held      = 1'b1;
        hold_left = HOLD_LEN;
      end
      stall_pct = (phase == 0) ? 45 : (phase == 1) ? 26 : 0;
      if (hold_left > 0) begin
        hold_left--;
        face_stall <= 1'b1;
      end else begin
        face_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    face_exp_t want;
    if (!rst && face_valid && !face_stall) begin
      if (face_q.size() == 0) begin
        $error("face transfer with nothing expected: face_index %0d", face_index);
        errors++;
      end else begin
        want = face_q.pop_front();
        faces_checked++;
        if (face_index !== want.idx) begin
          $error("face_index: expected %0d, got %0d", want.idx, face_index);
          errors++;
        end
        if (face_colors !== want.cols) begin
          $error("face_colors: expected %h, got %h", want.cols, face_colors);
          errors++;
        end
        if (invalid !== want.bad) begin
          $error("invalid: expected %0b, got %0b", want.bad, invalid);
          errors++;
        end
        if (last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last);
          errors++;
        end
      end
    end
  end

  initial begin
    #400000;
    $display("Timeout with %0d faces still expected", face_q.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
